FILE: sv/mbet_pkg.sv
// mbet_pkg: shared types, constants and the saturation helper for the
// escape-time pixel block. No dependencies.
package mbet_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int STEP_FRAC  = 28;
  localparam int STEP_W     = 29;
  localparam int CNT_W      = 8;
  localparam int CH_W       = 8;
  localparam int CFG_W      = 29;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH_DEF = 2;

  // Q4.FRAC value, product after the fraction shift, and a sum with headroom
  localparam int VAL_W  = FRAC_BITS + 4;
  localparam int PROD_W = VAL_W + 4;
  localparam int SUM_W  = PROD_W + 1;

  // pixel times step, exact
  localparam int PIXPROD_W = COORD_BITS + STEP_W;

  // divider sizes for count*255 over the limit or count+8
  localparam int DVD_W = 2 * CNT_W;
  localparam int DVS_W = CNT_W + 1;

  localparam logic [CH_W-1:0]  CH_MAX      = 8'd255;
  localparam logic [DVS_W-1:0] COLOUR_BIAS = 9'd8;
  localparam logic [PIXPROD_W-1:0] COORD_LIM = PIXPROD_W'(64'd10 << STEP_FRAC);

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam sum_t SAT_HI = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam sum_t SAT_LO = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
  localparam sum_t FOUR_Q   = sum_t'(64'd4 << FRAC_BITS);
  localparam sum_t ORIGIN_X = -sum_t'(64'd2 << FRAC_BITS);
  localparam sum_t ORIGIN_Y = -sum_t'(64'd1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER    = 2'd0,
    REG_X_STEP      = 2'd1,
    REG_Y_STEP      = 2'd2,
    REG_COLOUR_MODE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic [CNT_W-1:0] escape_count;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]  max_iterations;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic              colour_mode;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    max_iterations: 8'd60,
    x_step:         29'd786432,
    y_step:         29'd745654,
    colour_mode:    1'b0
  };

  typedef struct packed {
    val_t cr;
    val_t ci;
  } cpoint_t;

  // clamp to the Q4.FRAC range
  function automatic val_t sat_val(sum_t v);
    if (v > SAT_HI) begin
      return SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

FILE: sv/mandelbrot_escape_time_pixel.sv
// mandelbrot_escape_time_pixel: top level, config registers and result register.
// Depends on mbet_pkg, mbet_front, mbet_fifo, mbet_div and mbet_core.
//
// usage
//   input channel: drive pix_i and raise push; a transfer happens on a clock
//   edge with push high and full low. full rises only when the mapping stage
//   holds a point and the point queue is also full
//   result channel: while empty is low, res_o carries the oldest result; a
//   transfer happens on an edge with pop high. a result waiting on res_o does
//   not block new pixels: the front keeps mapping into the queue and the core
//   starts the next point, stalling only when it has a second result ready
//   config: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
//   (limit, x step, y step, colour mode); the user writes only while the block
//   is idle, which the block itself does not enforce
// stages
//   front: a registered multiply, then the mapped point enters the queue
//   core: load, then per iteration a product register and add/compare/saturate,
//   then finish, the serial divide when the point escapes, and the hand-over
//   of the result; an escaping point spends one extra iteration slot on the
//   escape test itself. the default limit is 60.
//   the iteration loop sets the rate, one pixel in the core at a time
// reset
//   all config registers return to their defaults, queue and result
//   register empty, core idle
module mandelbrot_escape_time_pixel import mbet_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  pix_t                 pix_i,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t             cfg_q;
  logic             q_push, q_full, q_pop, q_empty;
  cpoint_t          q_wdata, q_rdata;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dividend, div_quot;
  logic [DVS_W-1:0] div_divisor;
  logic             core_valid, core_ready;
  res_t             core_res;
  logic             out_full_q;
  res_t             out_q;

  // config registers, written field by field
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_ITER:    cfg_q.max_iterations <= cfg_wdata_i[CNT_W-1:0];
        REG_X_STEP:      cfg_q.x_step         <= cfg_wdata_i[STEP_W-1:0];
        REG_Y_STEP:      cfg_q.y_step         <= cfg_wdata_i[STEP_W-1:0];
        REG_COLOUR_MODE: cfg_q.colour_mode    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // pixel to point mapping
  mbet_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .full_o      (full),
    .pix_i       (pix_i),
    .fifo_full_i (q_full),
    .fifo_push_o (q_push),
    .fifo_data_o (q_wdata)
  );

  // decoupling queue between mapping and iteration
  mbet_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // iteration sequencer and colour mapping
  mbet_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fifo_empty_i   (q_empty),
    .fifo_data_i    (q_rdata),
    .fifo_pop_o     (q_pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .res_valid_o    (core_valid),
    .res_ready_i    (core_ready),
    .res_o          (core_res)
  );

  // shared serial divider for both colour maps
  mbet_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // result register, refilled in the same cycle as a pop
  assign core_ready = ~out_full_q | pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (core_valid && core_ready) begin
      out_full_q <= 1'b1;
    end else if (pop) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid && core_ready) begin
      out_q <= core_res;
    end
  end

  assign empty = ~out_full_q;
  assign res_o = out_q;

  // the result register drains only through a pop transfer
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_full_q) |-> $past(pop))
    else $error("result register emptied without a pop transfer");

  // blue is zero only for a point inside the set, and then the pixel is black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_valid && core_res.blue == '0) |-> (core_res.red == '0 && core_res.green == '0))
    else $error("partly black colour from the core");

  // a divide start never repeats back to back
  a_div_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_start)
    else $error("divider restarted back to back");

endmodule

FILE: sv/mbet_front.sv
// mbet_front: takes pixel items and maps them to the complex point c.
// Depends on mbet_pkg.
module mbet_front import mbet_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    push_i,
  output logic    full_o,
  input  pix_t    pix_i,
  input  logic    fifo_full_i,
  output logic    fifo_push_o,
  output cpoint_t fifo_data_o
);

  localparam int SHL = (FRAC_BITS >= STEP_FRAC) ? FRAC_BITS - STEP_FRAC : 0;
  localparam int SHR = (FRAC_BITS >= STEP_FRAC) ? 0 : STEP_FRAC - FRAC_BITS;

  logic                 stg_valid_q, stg_valid_d;
  logic [PIXPROD_W-1:0] prod_x_q, prod_y_q;
  logic                 accept;

  function automatic val_t to_coord(logic [PIXPROD_W-1:0] prod, sum_t origin);
    logic [PIXPROD_W-1:0] lim;
    logic [SUM_W-1:0]     v;
    lim = (prod > COORD_LIM) ? COORD_LIM : prod;
    v   = (SUM_W'(lim) << SHL) >> SHR;
    return sat_val(origin + sum_t'(v));
  endfunction

  assign full_o      = stg_valid_q & fifo_full_i;
  assign accept      = push_i & ~full_o;
  assign fifo_push_o = stg_valid_q & ~fifo_full_i;
  assign stg_valid_d = accept | (stg_valid_q & fifo_full_i);

  assign fifo_data_o.cr = to_coord(prod_x_q, ORIGIN_X);
  assign fifo_data_o.ci = to_coord(prod_y_q, ORIGIN_Y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_x_q <= PIXPROD_W'(pix_i.pixel_x) * PIXPROD_W'(cfg_i.x_step);
      prod_y_q <= PIXPROD_W'(pix_i.pixel_y) * PIXPROD_W'(cfg_i.y_step);
    end
  end

endmodule

FILE: sv/mbet_fifo.sv
// mbet_fifo: short queue of mapped points between front and core.
// Depends on mbet_pkg.
module mbet_fifo import mbet_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cpoint_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output cpoint_t data_o,
  output logic    empty_o
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEVEL_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [LEVEL_W-1:0] FULL_LVL = LEVEL_W'(DEPTH);

  cpoint_t            mem_q [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LEVEL_W-1:0] level_q;
  logic               do_push, do_pop;

  assign full_o  = (level_q == FULL_LVL);
  assign empty_o = (level_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + 1'b1;
      end else if (do_pop && !do_push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/mbet_div.sv
// mbet_div: restoring divider, one quotient bit per cycle.
// Depends on mbet_pkg.
module mbet_div import mbet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int STEP_CW = $clog2(DVD_W);
  localparam logic [STEP_CW-1:0] LAST_STEP = STEP_CW'(DVD_W - 1);

  logic               busy_q, done_q;
  logic [STEP_CW-1:0] cnt_q;
  logic [DVS_W-1:0]   rem_q, dvs_q;
  logic [DVD_W-1:0]   sh_q;
  logic [DVS_W:0]     trial, diff;
  logic               fits;

  assign trial = {rem_q, sh_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  assign done_o     = done_q;
  assign quotient_o = sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & (cnt_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      sh_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      sh_q  <= {sh_q[DVD_W-2:0], fits};
    end
  end

endmodule

FILE: sv/mbet_core.sv
// mbet_core: escape-time iteration and colour mapping for one point at a time.
// Depends on mbet_pkg; drives mbet_div from outside.
module mbet_core import mbet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             fifo_empty_i,
  input  cpoint_t          fifo_data_i,
  output logic             fifo_pop_o,
  output logic             div_start_o,
  output logic [DVD_W-1:0] div_dividend_o,
  output logic [DVS_W-1:0] div_divisor_o,
  input  logic             div_done_i,
  input  logic [DVD_W-1:0] div_quot_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_FIN, S_DIV, S_DONE
  } state_e;

  state_e           state_q;
  val_t             cr_q, ci_q, zr_q, zi_q;
  prod_t            rr_q, ii_q, ri_q;
  logic [CNT_W-1:0] m_q;
  res_t             res_q;

  logic signed [2*VAL_W-1:0] p_rr, p_ii, p_ri;
  sum_t             mag_sum, nr, ni;
  logic             escape, in_set;
  logic [CNT_W-1:0] m_inc;
  logic [CH_W-1:0]  quot;

  assign p_rr = zr_q * zr_q;
  assign p_ii = zi_q * zi_q;
  assign p_ri = zr_q * zi_q;

  assign mag_sum = sum_t'(rr_q) + sum_t'(ii_q);
  assign escape  = (mag_sum > FOUR_Q);
  assign nr      = sum_t'(rr_q) - sum_t'(ii_q) + sum_t'(cr_q);
  assign ni      = (sum_t'(ri_q) <<< 1) + sum_t'(ci_q);
  assign m_inc   = m_q + 1'b1;
  assign in_set  = (m_q >= cfg_i.max_iterations);
  assign quot    = div_quot_i[CH_W-1:0];

  assign fifo_pop_o     = (state_q == S_IDLE) & ~fifo_empty_i;
  assign div_start_o    = (state_q == S_FIN) & ~in_set;
  assign div_dividend_o = DVD_W'(m_q) * DVD_W'(CH_MAX);
  assign div_divisor_o  = cfg_i.colour_mode ? ({1'b0, m_q} + COLOUR_BIAS)
                                            : {1'b0, cfg_i.max_iterations};
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o          = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!fifo_empty_i) begin
            cr_q    <= fifo_data_i.cr;
            ci_q    <= fifo_data_i.ci;
            zr_q    <= fifo_data_i.cr;
            zi_q    <= fifo_data_i.ci;
            m_q     <= '0;
            state_q <= (cfg_i.max_iterations == '0) ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          rr_q    <= p_rr[2*VAL_W-1:FRAC_BITS];
          ii_q    <= p_ii[2*VAL_W-1:FRAC_BITS];
          ri_q    <= p_ri[2*VAL_W-1:FRAC_BITS];
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (escape) begin
            state_q <= S_FIN;
          end else begin
            zr_q    <= sat_val(nr);
            zi_q    <= sat_val(ni);
            m_q     <= m_inc;
            state_q <= (m_inc < cfg_i.max_iterations) ? S_MUL : S_FIN;
          end
        end
        S_FIN: begin
          if (in_set) begin
            res_q   <= '{escape_count: m_q, red: '0, green: '0, blue: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done_i) begin
            if (cfg_i.colour_mode) begin
              res_q <= '{escape_count: m_q, red: m_q, green: quot, blue: CH_MAX};
            end else begin
              res_q <= '{escape_count: m_q, red: CH_MAX - quot,
                         green: CH_MAX - quot, blue: CH_MAX - quot};
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
